// File: rtl/pnn_pkg.sv
// shared types and constants for the polygon normal unit
package pnn_pkg;

  localparam int SUM_W      = 58;            // newell sum width, wraps modulo 2^58
  localparam int MAG_W      = 30;            // magnitude width after scaling
  localparam int SQ_W       = 2 * MAG_W;     // one squared magnitude
  localparam int S_W        = SQ_W + 2;      // sum of three squares
  localparam int REM_W      = S_W + 1;       // divider partial remainder
  localparam int DIV_STEPS  = MAG_W;         // quotient bits of v^2*2^30/S
  localparam int ROOT_W     = 15;            // root bits of a Q1.15 magnitude
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int NORM_W     = 16;
  localparam int NUM_AXES   = 3;
  localparam int SEL_W      = 2;
  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_AXES - 1);
  localparam logic [NORM_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [NORM_W-1:0] SAT_NEG = 16'h8000;
  localparam int MIN_VERTICES = 3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EDGE_MUL,
    OP_CLOSE_MUL,
    OP_ACC,
    OP_MAG,
    OP_SHIFT,
    OP_SQ,
    OP_SAT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_STORE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [SEL_W-1:0] sel;
    logic             deg;
  } pnn_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_ge3;
    logic mags_zero;
    logic shift_needed;
    logic sq_ge_s;
  } pnn_stat_t;

endpackage

// File: rtl/pnn_vtx_if.sv
// vertex input channel
interface pnn_vtx_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

// File: rtl/pnn_nrm_if.sv
// normal result channel
interface pnn_nrm_if import pnn_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic                     degenerate;

  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// File: rtl/pnn_ctrl.sv
// sequencer for accumulation and normalization
module pnn_ctrl import pnn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pnn_stat_t stat,
  output pnn_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_MUL,
    S_EDGE_ACC,
    S_CLOSE_MUL,
    S_CLOSE_ACC,
    S_MAG,
    S_NORM,
    S_SQ,
    S_COMP,
    S_DIV,
    S_SQRT_INIT,
    S_SQRT,
    S_STORE,
    S_PUBLISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              deg_r, deg_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    step_nxt      = step_r;
    deg_nxt       = deg_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.sel       = sel_r;
    cmd.deg       = deg_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op   = OP_LOAD;
          last_nxt = in_last;
          if (!stat.count_zero) state_nxt = S_EDGE_MUL;
          else if (in_last)     state_nxt = S_CLOSE_MUL;
        end
      end
      S_EDGE_MUL: begin
        cmd.op    = OP_EDGE_MUL;
        state_nxt = S_EDGE_ACC;
      end
      S_EDGE_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = last_r ? S_CLOSE_MUL : S_IDLE;
      end
      S_CLOSE_MUL: begin
        cmd.op    = OP_CLOSE_MUL;
        state_nxt = S_CLOSE_ACC;
      end
      S_CLOSE_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (!stat.count_ge3 || stat.mags_zero) begin
          deg_nxt   = 1'b1;
          state_nxt = S_PUBLISH;
        end else if (stat.shift_needed) begin
          cmd.op = OP_SHIFT;
        end else begin
          sel_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (sel_r == SEL_LAST) begin
          sel_nxt   = '0;
          state_nxt = S_COMP;
        end else begin
          sel_nxt = sel_r + 1'b1;
        end
      end
      S_COMP: begin
        if (stat.sq_ge_s) begin
          cmd.op = OP_SAT;
          if (sel_r == SEL_LAST) state_nxt = S_PUBLISH;
          else sel_nxt = sel_r + 1'b1;
        end else begin
          cmd.op    = OP_DIV_INIT;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_SQRT_INIT;
        else step_nxt = step_r + 1'b1;
      end
      S_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_STORE;
        else step_nxt = step_r + 1'b1;
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (sel_r == SEL_LAST) begin
          state_nxt = S_PUBLISH;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_COMP;
        end
      end
      S_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          deg_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      step_r      <= '0;
      deg_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      step_r      <= step_nxt;
      deg_r       <= deg_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a vertex that opens an edge or ends a loop keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (!stat.count_zero || in_last)) |=> !in_ready)
    else $error("accepted vertex did not take the sequencer out of idle");

  // a new result never overwrites one still waiting for transfer
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUBLISH) |-> (!out_valid_r || out_ready))
    else $error("result published over a pending result");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r < STEP_W'(DIV_STEPS)))
    else $error("divider step count out of range");
`endif

endmodule

// File: rtl/pnn_datapath.sv
// newell accumulation, scaling, division and square root datapath
module pnn_datapath import pnn_pkg::*; #(
  parameter int COORD_BITS        = 24,
  parameter int MAX_LOOP_VERTICES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  input  pnn_cmd_t                     cmd,
  output pnn_stat_t                    stat,
  output logic signed [NORM_W-1:0]     norm_x,
  output logic signed [NORM_W-1:0]     norm_y,
  output logic signed [NORM_W-1:0]     norm_z,
  output logic                         degenerate
);

  localparam int D_W    = COORD_BITS + 1;
  localparam int PROD_W = 2 * D_W;
  localparam int CNT_W  = $clog2(MAX_LOOP_VERTICES + 1);

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, cur_z_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, first_z_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [PROD_W-1:0]     prod_x_r, prod_y_r, prod_z_r;
  logic signed [SUM_W-1:0]      sum_x_r, sum_y_r, sum_z_r;
  logic [CNT_W-1:0]             count_r;

  logic [SUM_W-1:0]  mag_r [NUM_AXES];
  logic              neg_r [NUM_AXES];
  logic [SQ_W-1:0]   sq_r  [NUM_AXES];
  logic [NORM_W-1:0] res_r [NUM_AXES];
  logic [S_W-1:0]    s_r;
  logic [REM_W-1:0]  rem_r;
  logic [MAG_W-1:0]  quo_r;
  logic [ROOT_W-1:0] root_r, sqrt_bit_r;

  logic signed [NORM_W-1:0] norm_x_r, norm_y_r, norm_z_r;
  logic                     deg_out_r;

  // edge operands: (prev, cur) for a running edge, (cur, first) to close
  logic                         closing;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic signed [D_W-1:0]        d_x, d_y, d_z, s_x, s_y, s_z;
  logic signed [PROD_W-1:0]     p_x, p_y, p_z;

  assign closing = (cmd.op == OP_CLOSE_MUL);
  assign a_x = closing ? cur_x_r : prev_x_r;
  assign a_y = closing ? cur_y_r : prev_y_r;
  assign a_z = closing ? cur_z_r : prev_z_r;
  assign b_x = closing ? first_x_r : cur_x_r;
  assign b_y = closing ? first_y_r : cur_y_r;
  assign b_z = closing ? first_z_r : cur_z_r;
  assign d_x = D_W'(a_x) - D_W'(b_x);
  assign d_y = D_W'(a_y) - D_W'(b_y);
  assign d_z = D_W'(a_z) - D_W'(b_z);
  assign s_x = D_W'(a_x) + D_W'(b_x);
  assign s_y = D_W'(a_y) + D_W'(b_y);
  assign s_z = D_W'(a_z) + D_W'(b_z);
  assign p_x = d_y * s_z;
  assign p_y = d_z * s_x;
  assign p_z = d_x * s_y;

  logic [SUM_W-1:0]  abs_x, abs_y, abs_z, mag_or;
  logic [MAG_W-1:0]  v_sel;
  logic [SQ_W-1:0]   v_sq;
  logic [REM_W-1:0]  rem_sh, s_ext;
  logic              rem_ge;
  logic [ROOT_W-1:0] root_try;
  logic [MAG_W-1:0]  root_sq;

  assign abs_x  = sum_x_r[SUM_W-1] ? (~sum_x_r + 1'b1) : sum_x_r;
  assign abs_y  = sum_y_r[SUM_W-1] ? (~sum_y_r + 1'b1) : sum_y_r;
  assign abs_z  = sum_z_r[SUM_W-1] ? (~sum_z_r + 1'b1) : sum_z_r;
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];
  assign v_sel  = mag_r[cmd.sel][MAG_W-1:0];
  assign v_sq   = v_sel * v_sel;
  assign s_ext  = REM_W'(s_r);
  assign rem_sh = {rem_r[REM_W-2:0], 1'b0};
  assign rem_ge = (rem_sh >= s_ext);
  assign root_try = root_r | sqrt_bit_r;
  assign root_sq  = root_try * root_try;

  assign stat.count_zero   = (count_r == '0);
  assign stat.count_ge3    = (count_r >= CNT_W'(MIN_VERTICES));
  assign stat.mags_zero    = (mag_or == '0);
  assign stat.shift_needed = |mag_or[SUM_W-1:MAG_W];
  assign stat.sq_ge_s      = (S_W'(sq_r[cmd.sel]) >= s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      sum_z_r    <= '0;
      count_r    <= '0;
      sqrt_bit_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          cur_x_r <= pos_x;
          cur_y_r <= pos_y;
          cur_z_r <= pos_z;
          if (count_r == '0) begin
            first_x_r <= pos_x;
            first_y_r <= pos_y;
            first_z_r <= pos_z;
            prev_x_r  <= pos_x;
            prev_y_r  <= pos_y;
            prev_z_r  <= pos_z;
          end
          if (count_r < CNT_W'(MAX_LOOP_VERTICES)) count_r <= count_r + 1'b1;
        end
        OP_EDGE_MUL, OP_CLOSE_MUL: begin
          prod_x_r <= p_x;
          prod_y_r <= p_y;
          prod_z_r <= p_z;
        end
        OP_ACC: begin
          sum_x_r  <= sum_x_r + SUM_W'(prod_x_r);
          sum_y_r  <= sum_y_r + SUM_W'(prod_y_r);
          sum_z_r  <= sum_z_r + SUM_W'(prod_z_r);
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          prev_z_r <= cur_z_r;
        end
        OP_MAG: begin
          mag_r[0] <= abs_x;
          mag_r[1] <= abs_y;
          mag_r[2] <= abs_z;
          neg_r[0] <= sum_x_r[SUM_W-1];
          neg_r[1] <= sum_y_r[SUM_W-1];
          neg_r[2] <= sum_z_r[SUM_W-1];
        end
        OP_SHIFT: begin
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end
        OP_SQ: begin
          sq_r[cmd.sel] <= v_sq;
          s_r <= ((cmd.sel == '0) ? '0 : s_r) + S_W'(v_sq);
        end
        OP_SAT: begin
          res_r[cmd.sel] <= neg_r[cmd.sel] ? SAT_NEG : SAT_POS;
        end
        OP_DIV_INIT: begin
          rem_r <= REM_W'(sq_r[cmd.sel]);
          quo_r <= '0;
        end
        OP_DIV_STEP: begin
          rem_r <= rem_ge ? (rem_sh - s_ext) : rem_sh;
          quo_r <= {quo_r[MAG_W-2:0], rem_ge};
        end
        OP_SQRT_INIT: begin
          root_r     <= '0;
          sqrt_bit_r <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
        OP_SQRT_STEP: begin
          if (root_sq <= quo_r) root_r <= root_try;
          sqrt_bit_r <= sqrt_bit_r >> 1;
        end
        OP_STORE: begin
          res_r[cmd.sel] <= neg_r[cmd.sel] ? (NORM_W'(0) - NORM_W'(root_r))
                                           : NORM_W'(root_r);
        end
        OP_PUBLISH: begin
          norm_x_r  <= cmd.deg ? '0 : res_r[0];
          norm_y_r  <= cmd.deg ? '0 : res_r[1];
          norm_z_r  <= cmd.deg ? '0 : res_r[2];
          deg_out_r <= cmd.deg;
          sum_x_r   <= '0;
          sum_y_r   <= '0;
          sum_z_r   <= '0;
          count_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  assign norm_x     = norm_x_r;
  assign norm_y     = norm_y_r;
  assign norm_z     = norm_z_r;
  assign degenerate = deg_out_r;

`ifndef ASSERT_OFF
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sqrt_bit_r))
    else $error("square root bit mask not one-hot");

  // restoring division keeps the partial remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_STEP) |=> (rem_r < REM_W'(s_r)))
    else $error("divider remainder not below divisor");
`endif

endmodule

// File: rtl/polygon_normal_newell_unit.sv
// top level of the newell polygon normal unit
// usage:
//   in_vtx carries one vertex per transfer (pos_x/y/z, signed Q12.12) in
//   loop order; last_vertex marks the final vertex of a polygon.
//   out_nrm carries one unit normal (norm_x/y/z, Q1.15) per polygon, with
//   degenerate set and zero components for loops under three vertices or
//   with zero area.
// sequence:
//   a vertex is accepted, its edge product formed and then accumulated; the
//   first vertex of a loop is only stored. after the last vertex the closing
//   edge, magnitude scaling (one right shift a cycle, up to 28 shifts), three
//   squares and, per unsaturated component, a restoring divider and a square
//   root run on shared units before the result is valid.
// reset:
//   synchronous, active low; clears the sums, the vertex count and the
//   pending result.
// stall:
//   a finished result waits in the output register; vertices of the next
//   polygon are taken meanwhile, and the unit holds before publishing only
//   when a second result is ready while the first still waits.
module polygon_normal_newell_unit import pnn_pkg::*; #(
  parameter int COORD_BITS        = 24,
  parameter int MAX_LOOP_VERTICES = 256
) (
  input logic        clk,
  input logic        rst_n,
  pnn_vtx_if.sink    in_vtx,
  pnn_nrm_if.source  out_nrm
);

  // command and status between sequencer and datapath
  pnn_cmd_t  cmd;
  pnn_stat_t stat;

  pnn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_last   (in_vtx.last_vertex),
    .in_ready  (in_vtx.ready),
    .out_valid (out_nrm.valid),
    .out_ready (out_nrm.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // accumulation, scaling and normalization
  pnn_datapath #(
    .COORD_BITS        (COORD_BITS),
    .MAX_LOOP_VERTICES (MAX_LOOP_VERTICES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .pos_x      (in_vtx.pos_x),
    .pos_y      (in_vtx.pos_y),
    .pos_z      (in_vtx.pos_z),
    .cmd        (cmd),
    .stat       (stat),
    .norm_x     (out_nrm.norm_x),
    .norm_y     (out_nrm.norm_y),
    .norm_z     (out_nrm.norm_z),
    .degenerate (out_nrm.degenerate)
  );

endmodule

// File: test/polygon_normal_newell_unit_test.sv
// testbench for the newell polygon normal unit: streamed vertex loops checked against a predictor
module polygon_normal_newell_unit_test import pnn_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam int LOOP_MAX = 256;
  localparam int SW = 58;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     degenerate;
  } normal_t;

  logic clk;
  logic rst_n;

  pnn_vtx_if #(.COORD_BITS(CW)) vtx ();
  pnn_nrm_if nrm ();

  polygon_normal_newell_unit #(.COORD_BITS(CW), .MAX_LOOP_VERTICES(LOOP_MAX)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (vtx.sink),
    .out_nrm(nrm.source)
  );

  // predictor state: first and previous vertex, exact newell sums, loop length
  logic signed [CW-1:0] first_v [3];
  logic signed [CW-1:0] prev_v [3];
  logic [SW-1:0]        newell_sum [3];
  int unsigned          loop_len;

  normal_t normal_queue [$];
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // add one edge (a,b) to the sums; coordinates widened before use
  function automatic void add_edge(input logic signed [CW-1:0] a [3],
                                   input logic signed [CW-1:0] b [3]);
    longint d;
    longint s;
    for (int k = 0; k < 3; k++) begin
      // axis k pairs with (k+1, k+2)
      d = longint'(a[(k + 1) % 3]) - longint'(b[(k + 1) % 3]);
      s = longint'(a[(k + 2) % 3]) + longint'(b[(k + 2) % 3]);
      newell_sum[k] = newell_sum[k] + SW'(d * s);
    end
  endfunction

  // largest r with r^2*S <= v^2*2^30, saturated at one
  function automatic logic signed [NORM_W-1:0] unit_part(input logic [63:0] v,
                                                          input logic [63:0] s,
                                                          input bit neg);
    logic [127:0] target;
    logic [127:0] trial;
    logic [15:0]  r;
    logic [15:0]  c;
    r = '0;
    if (v * v >= s) return neg ? SAT_NEG : SAT_POS;
    target = {64'b0, v * v} << 30;
    for (int b = 15; b >= 0; b--) begin
      c = r | (16'd1 << b);
      trial = 128'(c) * 128'(c) * 128'(s);
      if (trial <= target) r = c;
    end
    return neg ? -r : r;
  endfunction

  function automatic void clear_loop();
    for (int k = 0; k < 3; k++) begin
      first_v[k] = '0;
      prev_v[k] = '0;
      newell_sum[k] = '0;
    end
    loop_len = 0;
  endfunction

  // advance the predictor by one accepted vertex
  function automatic void predict_vertex(input logic signed [CW-1:0] p [3], input bit last);
    logic [63:0] mag [3];
    bit          neg [3];
    logic [63:0] peak;
    logic [63:0] sq;
    normal_t     n;
    if (loop_len == 0) first_v = p;
    else add_edge(prev_v, p);
    prev_v = p;
    if (loop_len < LOOP_MAX) loop_len++;
    if (!last) return;
    add_edge(p, first_v);
    n = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b1};
    for (int k = 0; k < 3; k++) begin
      neg[k] = newell_sum[k][SW-1];
      mag[k] = neg[k] ? -64'($signed(newell_sum[k])) : 64'(newell_sum[k]);
    end
    if (loop_len >= MIN_VERTICES && (mag[0] | mag[1] | mag[2]) != 0) begin
      peak = mag[0];
      if (mag[1] > peak) peak = mag[1];
      if (mag[2] > peak) peak = mag[2];
      while (peak >= (64'd1 << 30)) begin
        peak = peak >> 1;
        for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      end
      sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      n.nx = unit_part(mag[0], sq, neg[0]);
      n.ny = unit_part(mag[1], sq, neg[1]);
      n.nz = unit_part(mag[2], sq, neg[2]);
      n.degenerate = 1'b0;
    end
    normal_queue = {normal_queue, n};
    clear_loop();
  endfunction

  // offer one vertex until transferred, idling at random beforehand
  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z, input bit last);
    logic signed [CW-1:0] p [3];
    while ($urandom_range(99) < send_idle_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= x;
    vtx.pos_y <= y;
    vtx.pos_z <= z;
    vtx.last_vertex <= last;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    p[0] = x;
    p[1] = y;
    p[2] = z;
    predict_vertex(p, last);
    // valid stays high if another vertex follows at once; the next call lowers it on idle
  endtask

  task automatic idle_sender();
    vtx.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed($urandom_range(1 << 16)) - (1 << 15));
    endcase
  endfunction

  task automatic send_loop(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), i == count - 1);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (normal_queue.size() != 0) @(posedge clk);
  endtask

  // extremes, short loops, zero area, an axis-aligned square and triangle
  task automatic test_directed();
    localparam logic signed [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] PMIN = {1'b1, {(CW-1){1'b0}}};
    // lone vertex and a single edge: too short
    send_vertex(PMAX, PMIN, 0, 1'b1);
    send_vertex(1, 2, 3, 1'b0);
    send_vertex(4, 5, 6, 1'b1);
    // collinear triangle: zero area
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(4096, 4096, 4096, 1'b0);
    send_vertex(8192, 8192, 8192, 1'b1);
    // unit square in xy: exact +z, saturates
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(4096, 0, 0, 1'b0);
    send_vertex(4096, 4096, 0, 1'b0);
    send_vertex(0, 4096, 0, 1'b1);
    // reversed winding in yz: exact -x
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(0, 0, 4096, 1'b0);
    send_vertex(0, 4096, 4096, 1'b1);
    // full-scale triangle: widest sums and the deepest scaling
    send_vertex(PMIN, PMIN, PMAX, 1'b0);
    send_vertex(PMAX, PMIN, PMIN, 1'b0);
    send_vertex(PMIN, PMAX, PMIN, 1'b1);
    send_vertex(PMAX, PMAX, PMAX, 1'b0);
    send_vertex(PMIN, PMAX, PMIN, 1'b0);
    send_vertex(PMAX, PMIN, PMIN, 1'b0);
    send_vertex(-1, -1, -1, 1'b1);
    wait_drained();
  endtask

  // random loops, mostly well formed with a few short ones
  task automatic test_random(input int unsigned vertices);
    int unsigned n;
    int unsigned sent;
    sent = 0;
    while (sent < vertices) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      send_loop(n);
      sent += n;
      if ($urandom_range(4) == 0) idle_sender();
    end
    wait_drained();
  endtask

  // one loop past the vertex limit, sums still wrap exactly
  task automatic test_long_loop();
    send_loop(LOOP_MAX + 4);
    wait_drained();
  endtask

  // receiver holds off while loops keep coming, so the unit fills and stalls
  task automatic test_backpressure();
    hold_off_cycles = 2000;
    send_loop(3);
    send_loop(3);
    send_loop(4);
    send_loop(3);
    wait_drained();
  endtask

  // receiver side: random stalls, and a counted hold-off on request
  initial begin
    nrm.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        nrm.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        nrm.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // check each result transfer against the oldest expected normal
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && nrm.valid && nrm.ready) begin
      if (normal_queue.size() == 0) begin
        $error("normal with no polygon pending");
        error_count++;
      end else begin
        want = normal_queue.pop_front();
        if (nrm.norm_x !== want.nx) begin
          $error("norm_x expected %0d got %0d", want.nx, nrm.norm_x);
          error_count++;
        end
        if (nrm.norm_y !== want.ny) begin
          $error("norm_y expected %0d got %0d", want.ny, nrm.norm_y);
          error_count++;
        end
        if (nrm.norm_z !== want.nz) begin
          $error("norm_z expected %0d got %0d", want.nz, nrm.norm_z);
          error_count++;
        end
        if (nrm.degenerate !== want.degenerate) begin
          $error("degenerate expected %0d got %0d", want.degenerate, nrm.degenerate);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("polygon_normal_newell_unit_test NOT OK");
    $finish;
  end

  initial begin
    error_count = 0;
    hold_off_cycles = 0;
    send_idle_pct = 9;
    recv_idle_pct = 46;
    clear_loop();
    vtx.valid = 1'b0;
    vtx.pos_x = '0;
    vtx.pos_y = '0;
    vtx.pos_z = '0;
    vtx.last_vertex = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(60);
    send_idle_pct = 46;
    recv_idle_pct = 9;
    test_random(50);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_loop();
    test_random(50);

    idle_sender();
    repeat (300) @(posedge clk);
    if (error_count == 0 && normal_queue.size() == 0)
      $display("polygon_normal_newell_unit_test OK");
    else
      $display("polygon_normal_newell_unit_test NOT OK");
    $finish;
  end
endmodule
